/* sv/ntip_pkg.sv */
// ----------------------------------------------------------------------------
// ntip_pkg
// Shared types and constants of the NTLM challenge target-info parser.
// ----------------------------------------------------------------------------
package ntip_pkg;

    localparam logic [15:0] HEADER_BYTES = 16'd48;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;
    localparam logic [7:0]  TYPE_CHALLENGE = 8'd2;
    localparam logic [7:0]  CHAR_FIRST   = 8'd32;
    localparam logic [7:0]  CHAR_END     = 8'd127;
    localparam logic [6:0]  CHAR_SUBST   = 7'd63;
    localparam logic [2:0]  NAME_NONE    = 3'd7;
    localparam logic [15:0] ID_END_LIST  = 16'd0;
    localparam logic [15:0] ID_NAME_FIRST = 16'd1;
    localparam logic [15:0] ID_NAME_LAST = 16'd4;

    // "NTLMSSP\0"
    localparam logic [7:0] SIG_BYTES [8] = '{8'h4e, 8'h54, 8'h4c, 8'h4d,
                                             8'h53, 8'h53, 8'h50, 8'h00};

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_NAME_START = 2'd0,
        KIND_NAME_CHAR  = 2'd1,
        KIND_STATUS     = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_SIG   = 3'd2,
        ST_BAD_TYPE  = 3'd3,
        ST_IN_HEADER = 3'd4
    } status_t;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_SKIP   = 6'b000010,
        PH_PAIR   = 6'b000100,
        PH_LOW    = 6'b001000,
        PH_HIGH   = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    // Everything one input byte produces: at most one name result and at most one status.
    typedef struct packed {
        logic       has_name;
        logic       name_is_char;
        logic [1:0] sel;
        logic [6:0] ch;
        logic       has_status;
        status_t    status;
    } bundle_t;

    typedef struct packed {
        kind_t      kind;
        logic [1:0] sel;
        logic [6:0] ch;
        status_t    status;
        logic       last;
    } result_t;

endpackage

/* sv/ntip_front.sv */
// ----------------------------------------------------------------------------
// ntip_front
// Byte parser: checks the header, tracks the target-info region and walks
// the attribute pairs, producing at most one result bundle per byte.
// ----------------------------------------------------------------------------
module ntip_front #(
    parameter int unsigned MAX_MESSAGE_BYTES = 65535
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic [15:0]       message_length,
    input  logic              final_byte,
    output logic              push,
    output ntip_pkg::bundle_t bundle
);
    import ntip_pkg::*;

    logic [15:0] pos_reg, pos_next;
    logic        sig_good_reg, sig_good_next;
    logic        type_good_reg, type_good_next;
    logic [15:0] rlen_reg, rlen_next;
    logic [31:0] roff_reg, roff_next;
    logic [32:0] rend_reg, rend_next;
    phase_t      phase_reg, phase_next;
    logic [31:0] shift_reg, shift_next;
    logic [15:0] vleft_reg, vleft_next;
    logic [2:0]  name_reg, name_next;
    logic [7:0]  low_reg, low_next;

    localparam logic [15:0] MLEN_MAX = 16'(MAX_MESSAGE_BYTES);

    logic [15:0] mlen;
    logic [31:0] off47;
    logic [32:0] end47;
    logic [32:0] end_cur;
    logic        off_low_cur;
    logic        in_bounds;

    always_comb begin
        mlen        = (message_length > MLEN_MAX) ? MLEN_MAX : message_length;
        off47       = {data_byte, roff_reg[23:0]};
        end47       = {1'b0, off47} + {17'd0, rlen_reg};
        end_cur     = (pos_reg == 16'd47) ? end47 : rend_reg;
        off_low_cur = (pos_reg == 16'd47) ? (off47 < {16'd0, HEADER_BYTES})
                                          : (roff_reg < {16'd0, HEADER_BYTES});
        in_bounds   = end_cur <= {17'd0, mlen};
    end

    always_comb begin
        phase_t      ph;
        logic [15:0] cnt;
        logic [31:0] sh;
        logic [31:0] sh_n;
        logic [15:0] id;
        logic [15:0] vlen;
        logic [16:0] pair_end;
        logic [2:0]  nm;

        pos_next       = pos_reg;
        sig_good_next  = sig_good_reg;
        type_good_next = type_good_reg;
        rlen_next      = rlen_reg;
        roff_next      = roff_reg;
        rend_next      = rend_reg;
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        vleft_next     = vleft_reg;
        name_next      = name_reg;
        low_next       = low_reg;
        bundle         = '0;
        ph             = phase_reg;
        cnt            = vleft_reg;
        sh             = shift_reg;
        sh_n           = {data_byte, shift_reg[31:8]};
        id             = sh_n[15:0];
        vlen           = sh_n[31:16];
        pair_end       = {1'b0, pos_reg} + 17'd1 + {1'b0, vlen};
        nm             = NAME_NONE;

        if (accept) begin
            // fixed header fields
            if (pos_reg < 16'd8) begin
                if (data_byte != SIG_BYTES[pos_reg[2:0]]) sig_good_next = 1'b0;
            end else if (pos_reg < 16'd12) begin
                if (data_byte != ((pos_reg == 16'd8) ? TYPE_CHALLENGE : 8'd0))
                    type_good_next = 1'b0;
            end else if (pos_reg == 16'd40) begin
                rlen_next[7:0] = data_byte;
            end else if (pos_reg == 16'd41) begin
                rlen_next[15:8] = data_byte;
            end else if (pos_reg >= 16'd44 && pos_reg <= 16'd47) begin
                case (pos_reg[1:0])
                    2'd0:    roff_next[7:0]   = data_byte;
                    2'd1:    roff_next[15:8]  = data_byte;
                    2'd2:    roff_next[23:16] = data_byte;
                    default: roff_next[31:24] = data_byte;
                endcase
            end

            if (pos_reg == 16'd47) begin
                rend_next = end47;
                if (mlen >= HEADER_BYTES && sig_good_reg && type_good_reg &&
                    rlen_reg != 16'd0 && in_bounds && !off_low_cur) begin
                    phase_next = PH_SKIP;
                end else begin
                    phase_next = PH_DONE;
                end
            end else if (pos_reg > 16'd47) begin
                // region start reached: begin the first pair header
                if (ph == PH_SKIP && {16'd0, pos_reg} >= roff_reg) begin
                    ph   = PH_PAIR;
                    cnt  = 16'd0;
                    sh   = 32'd0;
                    sh_n = {data_byte, 24'd0};
                    id   = 16'd0;
                    vlen = {data_byte, 8'd0};
                    pair_end = {1'b0, pos_reg} + 17'd1 + {1'b0, vlen};
                    phase_next = PH_PAIR;
                    vleft_next = cnt;
                    shift_next = sh;
                end

                if (ph == PH_PAIR) begin
                    if ({17'd0, pos_reg} >= rend_reg) begin
                        phase_next = PH_DONE;
                    end else if (cnt != 16'd3) begin
                        shift_next = sh_n;
                        vleft_next = cnt + 16'd1;
                    end else if (id == ID_END_LIST || {16'd0, pair_end} > rend_reg) begin
                        shift_next = sh_n;
                        vleft_next = 16'd4;
                        phase_next = PH_DONE;
                    end else begin
                        if (id >= ID_NAME_FIRST && id <= ID_NAME_LAST) begin
                            nm = 3'(id - 16'd1);
                        end
                        name_next = nm;
                        if (nm != NAME_NONE) begin
                            bundle.has_name     = 1'b1;
                            bundle.name_is_char = 1'b0;
                            bundle.sel          = nm[1:0];
                        end
                        vleft_next = vlen;
                        shift_next = 32'd0;
                        phase_next = (vlen == 16'd0) ? PH_PAIR : PH_LOW;
                    end
                end else if (ph == PH_LOW || ph == PH_HIGH) begin
                    if (ph == PH_LOW) begin
                        low_next   = data_byte;
                        phase_next = PH_HIGH;
                    end else begin
                        if (name_reg != NAME_NONE) begin
                            bundle.has_name     = 1'b1;
                            bundle.name_is_char = 1'b1;
                            bundle.sel          = name_reg[1:0];
                            bundle.ch = (low_reg < CHAR_FIRST || low_reg >= CHAR_END)
                                        ? CHAR_SUBST : low_reg[6:0];
                        end
                        phase_next = PH_LOW;
                    end
                    vleft_next = vleft_reg - 16'd1;
                    if (vleft_reg == 16'd1) begin
                        phase_next = PH_PAIR;
                        shift_next = 32'd0;
                    end
                end
            end

            if (pos_reg != POS_MAX) pos_next = pos_reg + 16'd1;

            if (final_byte) begin
                bundle.has_status = 1'b1;
                if (mlen < HEADER_BYTES || pos_next < HEADER_BYTES)
                    bundle.status = ST_SHORT;
                else if (!sig_good_next)
                    bundle.status = ST_BAD_SIG;
                else if (!type_good_next)
                    bundle.status = ST_BAD_TYPE;
                else if (rlen_reg != 16'd0 && in_bounds && off_low_cur)
                    bundle.status = ST_IN_HEADER;
                else
                    bundle.status = ST_OK;
                // return to the idle message state
                pos_next       = 16'd0;
                sig_good_next  = 1'b1;
                type_good_next = 1'b1;
                rlen_next      = 16'd0;
                roff_next      = 32'd0;
                rend_next      = 33'd0;
                phase_next     = PH_HEADER;
                shift_next     = 32'd0;
                vleft_next     = 16'd0;
                name_next      = NAME_NONE;
                low_next       = 8'd0;
            end
        end
    end

    assign push = accept && (bundle.has_name || bundle.has_status);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= 16'd0;
            sig_good_reg  <= 1'b1;
            type_good_reg <= 1'b1;
            rlen_reg      <= 16'd0;
            roff_reg      <= 32'd0;
            rend_reg      <= 33'd0;
            phase_reg     <= PH_HEADER;
            shift_reg     <= 32'd0;
            vleft_reg     <= 16'd0;
            name_reg      <= NAME_NONE;
            low_reg       <= 8'd0;
        end else begin
            pos_reg       <= pos_next;
            sig_good_reg  <= sig_good_next;
            type_good_reg <= type_good_next;
            rlen_reg      <= rlen_next;
            roff_reg      <= roff_next;
            rend_reg      <= rend_next;
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            vleft_reg     <= vleft_next;
            name_reg      <= name_next;
            low_reg       <= low_next;
        end
    end

endmodule

/* sv/ntip_fifo.sv */
// ----------------------------------------------------------------------------
// ntip_fifo
// Short queue of result bundles between the parser and the output stage.
// ----------------------------------------------------------------------------
module ntip_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ntip_pkg::bundle_t push_data,
    input  logic              pop,
    output ntip_pkg::bundle_t head,
    output logic              empty,
    output logic              full
);
    import ntip_pkg::*;

    bundle_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        if (pop)  rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)      count_next = count_reg + (QPTR_W+1)'(1);
        else if (pop && !push) count_next = count_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* sv/ntip_back.sv */
// ----------------------------------------------------------------------------
// ntip_back
// Output stage: splits each bundle into results and holds them in the
// output register until the sink takes them.
// ----------------------------------------------------------------------------
module ntip_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  ntip_pkg::bundle_t head,
    input  logic              empty,
    output logic              pop,
    input  logic              m_tready,
    output logic              m_tvalid,
    output ntip_pkg::result_t m_result
);
    import ntip_pkg::*;

    logic    valid_reg, valid_next;
    result_t result_reg, result_next;
    logic    part_reg, part_next;
    logic    load;

    assign load = !empty && (!valid_reg || m_tready);

    always_comb begin
        valid_next  = valid_reg;
        result_next = result_reg;
        part_next   = part_reg;
        pop         = 1'b0;
        if (valid_reg && m_tready) valid_next = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            if (head.has_name && !part_reg) begin
                result_next.kind   = head.name_is_char ? KIND_NAME_CHAR : KIND_NAME_START;
                result_next.sel    = head.sel;
                result_next.ch     = head.ch;
                result_next.status = ST_OK;
                result_next.last   = 1'b0;
                if (head.has_status) begin
                    part_next = 1'b1;
                end else begin
                    pop = 1'b1;
                end
            end else begin
                result_next.kind   = KIND_STATUS;
                result_next.sel    = 2'd0;
                result_next.ch     = 7'd0;
                result_next.status = head.status;
                result_next.last   = 1'b1;
                part_next          = 1'b0;
                pop                = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            part_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            part_reg  <= part_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

    // A split bundle stays at the head until its status goes out.
    a_part_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        part_reg |-> !empty)
        else $error("split bundle lost from queue head");

    // The last flag marks status results and nothing else.
    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (result_reg.last == (result_reg.kind == KIND_STATUS)))
        else $error("last flag does not match result kind");

    // A name result is followed by its status when both came from one byte.
    a_split_then_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && part_reg) |=> (valid_reg && result_reg.kind == KIND_STATUS))
        else $error("second half of split bundle is not a status");

endmodule

/* sv/ntlm_challenge_target_info_parser_top.sv */
// ----------------------------------------------------------------------------
// ntlm_challenge_target_info_parser_top
// NTLM challenge message parser: checks the header and emits the target-info
// computer and domain names as ASCII characters, then a status per message.
// ----------------------------------------------------------------------------
// Each accepted byte's results are written into the queue, then loaded into
// the output register that drives m_tvalid.
// Throughput: one byte per cycle while the queue has room (s_tready is low
// when it is full). A final byte that also yields a name result gives two
// results, which the output stage sends one after the other; the four-entry queue absorbs that.
// Reset: aresetn low for one clock clears the parse state, the queue and the
// output register; s_tready is high again on the first cycle after reset.
// ----------------------------------------------------------------------------
module ntlm_challenge_target_info_parser_top #(
    parameter int unsigned MAX_MESSAGE_BYTES = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] message_length
    input  logic        s_tlast,   // final_byte
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] ascii_char, [9:7] parse_status, rest zero
    output logic [3:0]  m_tuser,   // [1:0] result_kind, [3:2] name_select
    output logic        m_tlast    // last_result
);
    import ntip_pkg::*;

    logic    accept;
    logic    push;
    bundle_t push_data;
    bundle_t head;
    logic    q_empty;
    logic    q_full;
    logic    pop;
    result_t result;

    // Take a byte whenever out of reset and the queue has room; the back end
    // drains on its own.
    assign s_tready = aresetn && !q_full;
    assign accept   = s_tvalid && s_tready;

    ntip_front #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .data_byte      (s_tdata[7:0]),
        .message_length (s_tdata[23:8]),
        .final_byte     (s_tlast),
        .push           (push),
        .bundle         (push_data)
    );

    // Hold bundles so that a stalled sink does not stall the parser at once.
    ntip_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    ntip_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (q_empty),
        .pop      (pop),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_result (result)
    );

    // Pack the result fields onto the stream.
    assign m_tdata = {6'd0, result.status, result.ch};
    assign m_tuser = {result.sel, result.kind};
    assign m_tlast = result.last;

endmodule

/* dv/tb_ntlm_challenge_target_info_parser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ntlm_challenge_target_info_parser_top
// Self-checking bench for the NTLM challenge target-info parser. Whole messages
// are built byte by byte. Many are well-formed challenges with random
// attribute lists, and the rest carry header faults, odd regions, truncation,
// length changes and plain noise. A byte-level parser model runs on every
// accepted transaction and queues the expected name and status results. The
// monitor checks each result transaction against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_ntlm_challenge_target_info_parser_top;
    import ntip_pkg::*;

    // Message shapes the generator knows how to build.
    localparam int SC_EDGES         = 0;
    localparam int SC_GOOD          = 1;
    localparam int SC_BAD_PAIR      = 2;
    localparam int SC_NO_INFO       = 3;
    localparam int SC_IN_HEADER     = 4;
    localparam int SC_OUT_OF_BOUNDS = 5;
    localparam int SC_BAD_SIG       = 6;
    localparam int SC_BAD_TYPE      = 7;
    localparam int SC_SHORT         = 8;
    localparam int SC_EARLY_END     = 9;
    localparam int SC_LEN_CHANGE    = 10;
    localparam int SC_TRAILING      = 11;
    localparam int SC_NOISE         = 12;
    localparam int SC_LONG          = 13;

    // Attribute ids used by hand-built lists.
    localparam logic [15:0] AV_NB_COMPUTER  = 16'd1;
    localparam logic [15:0] AV_NB_DOMAIN    = 16'd2;
    localparam logic [15:0] AV_DNS_COMPUTER = 16'd3;
    localparam logic [15:0] AV_DNS_DOMAIN   = 16'd4;
    localparam logic [15:0] AV_TIMESTAMP    = 16'd7;

    // Low bytes around the printable range, plus both ends of the byte.
    localparam logic [7:0] EDGE_CHARS [7] = '{8'h00, 8'h1f, 8'h20, 8'h41,
                                              8'h7e, 8'h7f, 8'hff};

    localparam int unsigned LONG_MESSAGE_BYTES = 256;
    localparam int unsigned RANDOM_BYTES       = 500;

    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] mlen;
        logic        fin;
        logic        hold;   // wait for every expected result before sending
        logic [7:0]  idle;   // idle cycles before this byte
    } msg_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [7:0] data_byte, [23:8] message_length
    logic        s_tlast  = 1'b0; // final_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [6:0] ascii_char, [9:7] parse_status
    logic [3:0]  m_tuser;         // [1:0] result_kind, [3:2] name_select
    logic        m_tlast;         // last_result

    msg_byte_t   tx_bytes[$];
    result_t     pending_results[$];
    logic [7:0]  msg_bytes[$];
    logic [7:0]  info_bytes[$];

    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    bit          stim_done    = 1'b0;
    bit          armed        = 1'b0;
    int unsigned idle_left    = 0;
    int unsigned stall_left   = 0;
    int unsigned calm_left    = 0;

    // Parser model state.
    logic [15:0] rx_pos;
    logic        sig_ok;
    logic        type_ok;
    logic [15:0] info_len;
    logic [31:0] info_off;
    phase_t      walk;
    logic [31:0] hdr_shift;
    logic [15:0] walk_count;   // header bytes in PH_PAIR, value bytes left otherwise
    logic [2:0]  name_id;
    logic [7:0]  lo_hold;

    ntlm_challenge_target_info_parser_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    function automatic void clear_parser();
        rx_pos     = '0;
        sig_ok     = 1'b1;
        type_ok    = 1'b1;
        info_len   = '0;
        info_off   = '0;
        walk       = PH_HEADER;
        hdr_shift  = '0;
        walk_count = '0;
        name_id    = NAME_NONE;
        lo_hold    = '0;
    endfunction

    function automatic void expect_result(kind_t kind, logic [1:0] sel, logic [6:0] ch,
                                          status_t st, logic last);
        result_t r;
        r.kind   = kind;
        r.sel    = sel;
        r.ch     = ch;
        r.status = st;
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    // Advance the model by one accepted byte and queue what it yields.
    task automatic parse_byte(input logic [7:0] b, input logic [15:0] mlen, input logic fin);
        logic [15:0] p;
        logic [32:0] info_end;
        logic [32:0] pair_end;
        logic [15:0] pair_id;
        logic [15:0] pair_len;
        logic [6:0]  ch;
        status_t     st;
        p = rx_pos;

        // Fixed header fields.
        if (p < 16'd8) begin
            if (b != SIG_BYTES[p[2:0]])
                sig_ok = 1'b0;
        end else if (p < 16'd12) begin
            if (b != ((p == 16'd8) ? TYPE_CHALLENGE : 8'd0))
                type_ok = 1'b0;
        end else if (p == 16'd40) begin
            info_len[7:0] = b;
        end else if (p == 16'd41) begin
            info_len[15:8] = b;
        end else if (p >= 16'd44 && p <= 16'd47) begin
            info_off[8*p[1:0] +: 8] = b;
        end
        info_end = {1'b0, info_off} + {17'd0, info_len};

        if (p == HEADER_BYTES - 16'd1) begin
            // Admit the region on the length seen at the last header byte.
            if (mlen >= HEADER_BYTES && sig_ok && type_ok && info_len != 16'd0 &&
                info_end <= {17'd0, mlen} && info_off >= {16'd0, HEADER_BYTES})
                walk = PH_SKIP;
            else
                walk = PH_DONE;
        end else if (p >= HEADER_BYTES) begin
            if (walk == PH_SKIP && {16'd0, p} >= info_off) begin
                walk       = PH_PAIR;
                walk_count = '0;
                hdr_shift  = '0;
            end
            if (walk == PH_PAIR) begin
                if ({17'd0, p} >= info_end) begin
                    walk = PH_DONE;
                end else begin
                    hdr_shift  = {b, hdr_shift[31:8]};
                    walk_count = walk_count + 16'd1;
                    if (walk_count >= 16'd4) begin
                        pair_id  = hdr_shift[15:0];
                        pair_len = hdr_shift[31:16];
                        pair_end = {17'd0, p} + {17'd0, pair_len} + 33'd1;
                        if (pair_id == ID_END_LIST || pair_end > info_end) begin
                            walk = PH_DONE;
                        end else begin
                            if (pair_id >= ID_NAME_FIRST && pair_id <= ID_NAME_LAST) begin
                                name_id = pair_id[2:0] - 3'd1;
                                expect_result(KIND_NAME_START, name_id[1:0], 7'd0, ST_OK, 1'b0);
                            end else begin
                                name_id = NAME_NONE;
                            end
                            walk_count = pair_len;
                            hdr_shift  = '0;
                            if (pair_len == 16'd0)
                                walk = PH_PAIR;
                            else
                                walk = PH_LOW;
                        end
                    end
                end
            end else if (walk == PH_LOW || walk == PH_HIGH) begin
                if (walk == PH_LOW) begin
                    lo_hold = b;
                    walk    = PH_HIGH;
                end else begin
                    if (name_id != NAME_NONE) begin
                        if (lo_hold < CHAR_FIRST || lo_hold >= CHAR_END)
                            ch = CHAR_SUBST;
                        else
                            ch = lo_hold[6:0];
                        expect_result(KIND_NAME_CHAR, name_id[1:0], ch, ST_OK, 1'b0);
                    end
                    walk = PH_LOW;
                end
                walk_count = walk_count - 16'd1;
                if (walk_count == 16'd0) begin
                    walk      = PH_PAIR;
                    hdr_shift = '0;
                end
            end
        end

        if (rx_pos != POS_MAX)
            rx_pos = rx_pos + 16'd1;

        if (fin) begin
            if (mlen < HEADER_BYTES || rx_pos < HEADER_BYTES)
                st = ST_SHORT;
            else if (!sig_ok)
                st = ST_BAD_SIG;
            else if (!type_ok)
                st = ST_BAD_TYPE;
            else if (info_len != 16'd0 && info_end <= {17'd0, mlen} &&
                     info_off < {16'd0, HEADER_BYTES})
                st = ST_IN_HEADER;
            else
                st = ST_OK;
            expect_result(KIND_STATUS, 2'd0, 7'd0, st, 1'b1);
            clear_parser();
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------
    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic logic [7:0] pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 8'd0;
        if (r < 92)
            return 8'($urandom_range(1, 3));
        return 8'($urandom_range(6, 20));
    endfunction

    task automatic queue_byte(input logic [7:0] data, input logic [15:0] mlen, input logic fin,
                              input logic [7:0] idle, input logic hold);
        msg_byte_t t;
        t.data = data;
        t.mlen = mlen;
        t.fin  = fin;
        t.hold = hold;
        t.idle = idle;
        tx_bytes.push_back(t);
    endtask

    // Append one attribute pair; the value is UTF-16LE with mostly zero high bytes.
    task automatic add_pair(input logic [15:0] id, input logic [15:0] len, input bit edgy);
        int unsigned j;
        info_bytes.push_back(id[7:0]);
        info_bytes.push_back(id[15:8]);
        info_bytes.push_back(len[7:0]);
        info_bytes.push_back(len[15:8]);
        for (j = 0; j < len; j++) begin
            if (j % 2 == 1)
                info_bytes.push_back(
                    8'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : 0));
            else if (edgy)
                info_bytes.push_back(EDGE_CHARS[(j / 2) % 7]);
            else if ($urandom_range(0, 7) == 0)
                info_bytes.push_back(8'($urandom_range(0, 255)));
            else
                info_bytes.push_back(8'($urandom_range(32, 126)));
        end
    endtask

    task automatic queue_message(input int scen, input bit calm, input bit hold_first);
        int unsigned n_pairs;
        int unsigned pad;
        int unsigned k;
        int unsigned total;
        int unsigned cut;
        logic [31:0] ilen;
        logic [31:0] off_field;
        logic [15:0] decl;
        logic [15:0] pair_id;
        bit          wild;
        msg_bytes.delete();
        info_bytes.delete();
        wild = 1'b0;

        if (scen == SC_NOISE) begin
            total = $urandom_range(1, 70);
            for (k = 0; k < total; k++)
                msg_bytes.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 1)
                for (k = 0; k < 8 && k < total; k++)
                    msg_bytes[k] = SIG_BYTES[k];
            decl = 16'($urandom_range(0, 65535));
            wild = ($urandom_range(0, 3) == 0);
            cut  = total - 1;
        end else begin
            // Target-info region: attribute pairs, then usually an end-of-list pair.
            if (scen == SC_EDGES) begin
                add_pair(AV_NB_COMPUTER, 16'd11, 1'b1);
                add_pair(AV_NB_DOMAIN, 16'd0, 1'b1);
                add_pair(AV_TIMESTAMP, 16'd5, 1'b0);
                add_pair(AV_DNS_COMPUTER, 16'd14, 1'b1);
                add_pair(AV_DNS_DOMAIN, 16'd8, 1'b1);
            end else begin
                n_pairs = (scen == SC_LONG) ? 20 : $urandom_range((scen == SC_GOOD) ? 0 : 1, 3);
                for (k = 0; k < n_pairs; k++) begin
                    if ($urandom_range(0, 9) < 7)
                        pair_id = 16'($urandom_range(ID_NAME_FIRST, ID_NAME_LAST));
                    else
                        pair_id = 16'($urandom_range(ID_NAME_LAST + 1, 65535));
                    add_pair(pair_id,
                             16'(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 10)),
                             1'b0);
                end
            end
            if (scen == SC_BAD_PAIR) begin
                // Value length far past the region end.
                info_bytes.push_back(8'($urandom_range(ID_NAME_FIRST, ID_NAME_LAST)));
                info_bytes.push_back(8'd0);
                info_bytes.push_back(8'($urandom_range(0, 255)));
                info_bytes.push_back(8'($urandom_range(128, 255)));
                for (k = 0; k < 4; k++)
                    info_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (scen == SC_EDGES || $urandom_range(0, 3) != 0) begin
                for (k = 0; k < 4; k++)
                    info_bytes.push_back(8'd0);
            end
            for (k = $urandom_range(0, 3); k > 0; k--)
                info_bytes.push_back(8'($urandom_range(0, 255)));

            // Header with random filler, then padding, region and trailer.
            pad = $urandom_range(0, 6);
            for (k = 0; k < HEADER_BYTES + pad; k++)
                msg_bytes.push_back(8'($urandom_range(0, 255)));
            for (k = 0; k < 8; k++)
                msg_bytes[k] = SIG_BYTES[k];
            msg_bytes[8] = TYPE_CHALLENGE;
            for (k = 9; k < 12; k++)
                msg_bytes[k] = 8'd0;
            for (k = 0; k < info_bytes.size(); k++)
                msg_bytes.push_back(info_bytes[k]);
            for (k = $urandom_range(0, 5); k > 0; k--)
                msg_bytes.push_back(8'($urandom_range(0, 255)));
            if (scen == SC_LONG)
                while (msg_bytes.size() < LONG_MESSAGE_BYTES)
                    msg_bytes.push_back(8'($urandom_range(0, 255)));
            total     = msg_bytes.size();
            ilen      = info_bytes.size();
            off_field = HEADER_BYTES + pad;

            case (scen)
                SC_GOOD: begin
                    // Occasionally cut the region short so pairs run past its end.
                    if (ilen > 0 && $urandom_range(0, 6) == 0)
                        ilen = $urandom_range(1, ilen);
                end
                SC_NO_INFO: ilen = 0;
                SC_IN_HEADER: begin
                    off_field = $urandom_range(0, HEADER_BYTES - 1);
                    ilen      = $urandom_range(1, 40);
                    if (ilen > total - off_field)
                        ilen = total - off_field;
                end
                SC_OUT_OF_BOUNDS: begin
                    if ($urandom_range(0, 1) == 1) begin
                        ilen = total - off_field + $urandom_range(1, 200);
                        if (ilen > 65535)
                            ilen = 65535;
                    end else begin
                        off_field = ($urandom_range(1, 65535) << 16) | $urandom_range(0, 65535);
                        if (ilen == 0)
                            ilen = 1;
                    end
                end
                default: ;
            endcase
            msg_bytes[40] = ilen[7:0];
            msg_bytes[41] = ilen[15:8];
            for (k = 0; k < 4; k++)
                msg_bytes[44 + k] = off_field[8*k +: 8];

            if (scen == SC_BAD_SIG) begin
                k = $urandom_range(0, 7);
                msg_bytes[k] = msg_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
            end
            if (scen == SC_BAD_TYPE) begin
                k = $urandom_range(8, 11);
                msg_bytes[k] = msg_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
            end

            decl = (scen == SC_LONG) ? 16'hFFFF : total[15:0];
            if (scen == SC_GOOD && $urandom_range(0, 4) == 0)
                decl = 16'($urandom_range(total, 65535));
            cut = total - 1;
            case (scen)
                SC_EARLY_END: begin
                    if (total > HEADER_BYTES + 1)
                        cut = $urandom_range(HEADER_BYTES, total - 2);
                end
                SC_SHORT: begin
                    cut = $urandom_range(0, HEADER_BYTES - 2);
                    if ($urandom_range(0, 1) == 1)
                        decl = 16'($urandom_range(0, HEADER_BYTES - 1));
                end
                SC_TRAILING: begin
                    // Bytes beyond the declared length, still before the last mark.
                    for (k = $urandom_range(1, 10); k > 0; k--)
                        msg_bytes.push_back(8'($urandom_range(0, 255)));
                    cut = msg_bytes.size() - 1;
                end
                default: ;
            endcase
        end

        for (k = 0; k <= cut; k++)
            queue_byte(msg_bytes[k],
                       (wild || (k == cut && scen == SC_LEN_CHANGE)) ?
                           16'($urandom_range(0, 65535)) : decl,
                       k == cut, calm ? 8'd0 : pick_gap(), hold_first && k == 0);
    endtask

    // ------------------------------------------------------------------------
    // Driver: present queued bytes, honor idle gaps and drain holds, and run
    // the model on every accepted transaction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : byte_driver
        msg_byte_t head;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            armed     = 1'b0;
            idle_left = 0;
            clear_parser();
        end else begin
            if (s_tvalid && s_tready)
                parse_byte(s_tdata[7:0], s_tdata[23:8], s_tlast);
            // The slot is free when nothing is offered or the offer just went through.
            if (!s_tvalid || s_tready) begin
                if (tx_bytes.size() == 0) begin
                    s_tvalid <= 1'b0;
                    stim_done = 1'b1;
                end else begin
                    head = tx_bytes[0];
                    if (!armed) begin
                        idle_left = 32'(head.idle);
                        armed     = 1'b1;
                    end
                    if (idle_left > 0) begin
                        idle_left--;
                        s_tvalid <= 1'b0;
                    end else if (head.hold && pending_results.size() != 0) begin
                        // Hold off until every outstanding result has drained.
                        s_tvalid <= 1'b0;
                    end else begin
                        void'(tx_bytes.pop_front());
                        armed = 1'b0;
                        s_tvalid <= 1'b1;
                        s_tdata  <= {head.mlen, head.data};
                        s_tlast  <= head.fin;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result transaction, then pick the next stall.
    // ------------------------------------------------------------------------
    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    always @(posedge aclk) begin : result_monitor
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
            calm_left  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    log_mismatch($sformatf(
                        "result %0d unexpected: kind %0d sel %0d char %0d status %0d last %0d",
                        results_seen, m_tuser[1:0], m_tuser[3:2], m_tdata[6:0], m_tdata[9:7],
                        m_tlast));
                end else begin
                    want = pending_results.pop_front();
                    // Padding above parse_status must read as zero.
                    if ({m_tuser, m_tlast, m_tdata} !==
                        {want.sel, want.kind, want.last, 6'd0, want.status, want.ch}) begin
                        log_mismatch($sformatf(
                            {"result %0d: expected kind %0d sel %0d char %0d status %0d ",
                             "last %0d, got kind %0d sel %0d char %0d status %0d last %0d ",
                             "tdata %h"},
                            results_seen, want.kind, want.sel, want.ch, want.status,
                            want.last, m_tuser[1:0], m_tuser[3:2], m_tdata[6:0],
                            m_tdata[9:7], m_tlast, m_tdata));
                    end
                end
                // After a transaction: stall for a while, or stay ready in a calm stretch.
                if (calm_left > 0) begin
                    calm_left--;
                end else begin
                    stall_left = 32'(pick_gap());
                    if ($urandom_range(0, 49) == 0)
                        calm_left = $urandom_range(30, 120);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : run_control
        int unsigned random_count;
        int unsigned before_count;
        int unsigned r;
        int          scen;
        bit          long_done;
        random_count = 0;
        long_done    = 1'b0;

        // Directed: single-byte messages at both ends of every field, then one
        // message of each shape but the long one.
        queue_byte(8'h00, 16'h0000, 1'b1, 8'd0, 1'b0);
        queue_byte(8'hff, 16'hffff, 1'b1, 8'd0, 1'b0);
        for (scen = SC_EDGES; scen <= SC_NOISE; scen++)
            queue_message(scen, 1'b0, scen == SC_BAD_PAIR);

        // Random: well-formed challenges most often, plus one longer message with
        // many pairs sent without idle cycles.
        while (random_count < RANDOM_BYTES) begin
            before_count = tx_bytes.size();
            if (!long_done && random_count > RANDOM_BYTES / 2) begin
                queue_message(SC_LONG, 1'b1, 1'b1);
                long_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 40)      scen = SC_GOOD;
            else if (r < 46) scen = SC_BAD_PAIR;
            else if (r < 51) scen = SC_NO_INFO;
            else if (r < 56) scen = SC_IN_HEADER;
            else if (r < 62) scen = SC_OUT_OF_BOUNDS;
            else if (r < 67) scen = SC_BAD_SIG;
            else if (r < 71) scen = SC_BAD_TYPE;
            else if (r < 76) scen = SC_SHORT;
            else if (r < 82) scen = SC_EARLY_END;
            else if (r < 87) scen = SC_LEN_CHANGE;
            else if (r < 92) scen = SC_TRAILING;
            else             scen = SC_NOISE;
            queue_message(scen, $urandom_range(0, 6) == 0, $urandom_range(0, 24) == 0);
            random_count += tx_bytes.size() - before_count;
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(stim_done && pending_results.size() == 0))
            @(posedge aclk);
        // Let any stray result surface before the verdict.
        repeat (12) @(posedge aclk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #(64'd12_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
